@@ hw/rtl/plbm_pkg.sv @@
package plbm_pkg;

   // One stored hit; the packed order makes a plain compare lexicographic on
   // (record, field, paragraph, sentence, word).
   typedef struct packed {
      logic [23:0] record_no;
      logic [7:0]  field_no;
      logic [14:0] paragraph_no;
      logic [14:0] sentence_no;
      logic [14:0] word_pos;
   } entry_type;

   typedef enum logic [1:0] {
      CMD_LOAD_A = 2'd0,
      CMD_LOAD_B = 2'd1,
      CMD_RUN    = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_AND = 2'd0,
      MODE_OR  = 2'd1,
      MODE_XOR = 2'd2,
      MODE_NOT = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_STEP,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [23:0] record_no;
      logic [7:0]  field_no;
      logic [14:0] paragraph_no;
      logic [14:0] sentence_no;
      logic [14:0] word_pos;
   } req_type;

   typedef struct packed {
      logic        hit_valid;
      logic [23:0] out_record;
      logic [7:0]  out_field;
      logic [14:0] out_paragraph;
      logic [14:0] out_sentence;
      logic [14:0] out_word;
      logic        last;
      logic        overflow;
   } rsp_type;

   // Requests from the merge controller to the result buffer.
   typedef struct packed {
      logic      push;
      logic      finish;
      logic      overflow;
      entry_type hit;
   } buf_cmd_type;

endpackage

@@ hw/rtl/posting_list_boolean_merge.sv @@
// Loads are accepted back to back while idle; a load returns no result.
// A run walks the lists in merge steps (synchronous list read, then compare and
// advance); every step but the last advances a list; a step with a hit waits for the buffer.
// Each hit waits in a pending slot until the next hit or the close, so the final
// one can carry last. Synchronous active-high reset clears mode, counts and flags;
// list memories are not cleared, since only entries below the counts are ever used.
module posting_list_boolean_merge #(
   parameter int LIST_DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  plbm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output plbm_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_wr_data
);

   localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

   logic                  wr_a_en;
   logic                  wr_b_en;
   logic [AW-1:0]         wr_a_addr;
   logic [AW-1:0]         wr_b_addr;
   plbm_pkg::entry_type   wr_entry;
   logic                  rd_en;
   logic [AW-1:0]         rd_a_addr;
   logic [AW-1:0]         rd_b_addr;
   plbm_pkg::entry_type   rd_a_data;
   plbm_pkg::entry_type   rd_b_data;
   plbm_pkg::buf_cmd_type buf_cmd;
   logic                  buf_ready;

   // Walk sequencer, counters and mode register.
   plbm_merge_ctrl #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .wr_a_en     (wr_a_en),
      .wr_b_en     (wr_b_en),
      .wr_a_addr   (wr_a_addr),
      .wr_b_addr   (wr_b_addr),
      .wr_entry    (wr_entry),
      .rd_en       (rd_en),
      .rd_a_addr   (rd_a_addr),
      .rd_b_addr   (rd_b_addr),
      .rd_a_data   (rd_a_data),
      .rd_b_data   (rd_b_data),
      .buf_cmd     (buf_cmd),
      .buf_ready   (buf_ready)
   );

   // List A storage.
   plbm_list_mem #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_mem_a (
      .clock   (clock),
      .wr_en   (wr_a_en),
      .wr_addr (wr_a_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_a_addr),
      .rd_data (rd_a_data)
   );

   // List B storage.
   plbm_list_mem #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_mem_b (
      .clock   (clock),
      .wr_en   (wr_b_en),
      .wr_addr (wr_b_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_b_addr),
      .rd_data (rd_b_data)
   );

   // Pending slot and output register.
   plbm_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .buf_cmd   (buf_cmd),
      .buf_ready (buf_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ hw/rtl/plbm_list_mem.sv @@
module plbm_list_mem #(
   parameter int LIST_DEPTH = 32
) (
   input  logic                                           clock,
   input  logic                                           wr_en,
   input  logic [(LIST_DEPTH > 1 ? $clog2(LIST_DEPTH) : 1)-1:0] wr_addr,
   input  plbm_pkg::entry_type                            wr_data,
   input  logic                                           rd_en,
   input  logic [(LIST_DEPTH > 1 ? $clog2(LIST_DEPTH) : 1)-1:0] rd_addr,
   output plbm_pkg::entry_type                            rd_data
);

   plbm_pkg::entry_type mem_ff [LIST_DEPTH];
   plbm_pkg::entry_type rd_data_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read; the data holds until the next enabled read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/plbm_rsp_buf.sv @@
module plbm_rsp_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  plbm_pkg::buf_cmd_type buf_cmd,
   output logic                  buf_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output plbm_pkg::rsp_type     rsp_data
);

   // The newest hit waits here until the walk shows whether it is the last one.
   logic                pend_valid_ff;
   logic                pend_valid_in;
   plbm_pkg::entry_type pend_hit_ff;
   plbm_pkg::entry_type pend_hit_in;
   logic                pend_ovf_ff;
   logic                pend_ovf_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   plbm_pkg::rsp_type   rsp_ff;
   plbm_pkg::rsp_type   rsp_in;
   logic                out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign buf_ready = buf_cmd.push ? (!pend_valid_ff || out_free) : out_free;

   // Next values of the pending slot and the output register.
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_hit_in   = pend_hit_ff;
      pend_ovf_in   = pend_ovf_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (buf_cmd.push && buf_ready) begin
         if (pend_valid_ff) begin
            rsp_in.hit_valid     = 1'b1;
            rsp_in.out_record    = pend_hit_ff.record_no;
            rsp_in.out_field     = pend_hit_ff.field_no;
            rsp_in.out_paragraph = pend_hit_ff.paragraph_no;
            rsp_in.out_sentence  = pend_hit_ff.sentence_no;
            rsp_in.out_word      = pend_hit_ff.word_pos;
            rsp_in.last          = 1'b0;
            rsp_in.overflow      = pend_ovf_ff;
            rsp_valid_in         = 1'b1;
         end
         pend_valid_in = 1'b1;
         pend_hit_in   = buf_cmd.hit;
         pend_ovf_in   = buf_cmd.overflow;
      end else if (buf_cmd.finish && buf_ready) begin
         if (pend_valid_ff) begin
            rsp_in.hit_valid     = 1'b1;
            rsp_in.out_record    = pend_hit_ff.record_no;
            rsp_in.out_field     = pend_hit_ff.field_no;
            rsp_in.out_paragraph = pend_hit_ff.paragraph_no;
            rsp_in.out_sentence  = pend_hit_ff.sentence_no;
            rsp_in.out_word      = pend_hit_ff.word_pos;
            rsp_in.overflow      = pend_ovf_ff;
         end else begin
            // Empty merge: a single marker without a hit.
            rsp_in           = '0;
            rsp_in.overflow  = buf_cmd.overflow;
         end
         rsp_in.last   = 1'b1;
         rsp_valid_in  = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload.
   always_ff @(posedge clock) begin
      pend_hit_ff <= pend_hit_in;
      pend_ovf_ff <= pend_ovf_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // Closing a run always leaves a final transfer in the output register.
   assert property (@(posedge clock) disable iff (reset)
      (buf_cmd.finish && buf_ready) |=> (rsp_valid_ff && rsp_ff.last))
      else $error("finish did not produce a last result");

   // A hit displaced from the pending slot is never marked last.
   assert property (@(posedge clock) disable iff (reset)
      (buf_cmd.push && buf_ready && pend_valid_ff) |=> (rsp_valid_ff && !rsp_ff.last))
      else $error("displaced hit marked last");
`endif

endmodule

@@ hw/rtl/plbm_merge_ctrl.sv @@
module plbm_merge_ctrl #(
   parameter int LIST_DEPTH = 32
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           req_valid,
   output logic                                           req_stall,
   input  plbm_pkg::req_type                              req_data,
   input  logic                                           csr_wr_en,
   input  logic [1:0]                                     csr_wr_data,
   output logic                                           wr_a_en,
   output logic                                           wr_b_en,
   output logic [(LIST_DEPTH > 1 ? $clog2(LIST_DEPTH) : 1)-1:0] wr_a_addr,
   output logic [(LIST_DEPTH > 1 ? $clog2(LIST_DEPTH) : 1)-1:0] wr_b_addr,
   output plbm_pkg::entry_type                            wr_entry,
   output logic                                           rd_en,
   output logic [(LIST_DEPTH > 1 ? $clog2(LIST_DEPTH) : 1)-1:0] rd_a_addr,
   output logic [(LIST_DEPTH > 1 ? $clog2(LIST_DEPTH) : 1)-1:0] rd_b_addr,
   input  plbm_pkg::entry_type                            rd_a_data,
   input  plbm_pkg::entry_type                            rd_b_data,
   output plbm_pkg::buf_cmd_type                          buf_cmd,
   input  logic                                           buf_ready
);

   localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CW = $clog2(LIST_DEPTH + 1);

   plbm_pkg::state_type state_ff;
   plbm_pkg::state_type state_in;
   plbm_pkg::mode_type  mode_ff;
   plbm_pkg::mode_type  mode_in;
   logic [CW-1:0]       count_a_ff;
   logic [CW-1:0]       count_a_in;
   logic [CW-1:0]       count_b_ff;
   logic [CW-1:0]       count_b_in;
   logic [CW-1:0]       idx_a_ff;
   logic [CW-1:0]       idx_a_in;
   logic [CW-1:0]       idx_b_ff;
   logic [CW-1:0]       idx_b_in;
   logic [23:0]         skip_ff;
   logic [23:0]         skip_in;
   logic                dropped_ff;
   logic                dropped_in;

   logic req_take;
   logic a_left;
   logic b_left;
   logic a_full;
   logic b_full;
   logic rec_lt;
   logic rec_gt;
   logic key_lt;
   logic key_gt;
   logic is_xor;
   logic take_a;
   logic take_b;
   logic walk_done;
   logic emit_a;
   logic emit_b;
   logic inc_a;
   logic inc_b;
   logic set_skip;
   logic step_ok;

   assign req_stall = (state_ff != plbm_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   assign a_left = idx_a_ff < count_a_ff;
   assign b_left = idx_b_ff < count_b_ff;
   assign a_full = count_a_ff >= CW'(LIST_DEPTH);
   assign b_full = count_b_ff >= CW'(LIST_DEPTH);

   // Key comparison of the two heads read from the lists.
   assign rec_lt = rd_a_data.record_no < rd_b_data.record_no;
   assign rec_gt = rd_a_data.record_no > rd_b_data.record_no;
   assign key_lt = rd_a_data < rd_b_data;
   assign key_gt = rd_a_data > rd_b_data;
   assign is_xor = (mode_ff == plbm_pkg::MODE_XOR);

   // One merge step: which head is emitted and which index advances.
   always_comb begin
      walk_done = 1'b0;
      emit_a    = 1'b0;
      emit_b    = 1'b0;
      inc_a     = 1'b0;
      inc_b     = 1'b0;
      set_skip  = 1'b0;
      take_a    = 1'b0;
      take_b    = 1'b0;
      case (mode_ff)
         plbm_pkg::MODE_AND: begin
            if (!(a_left && b_left)) begin
               walk_done = 1'b1;
            end else if (rec_lt) begin
               inc_a = 1'b1;
            end else if (rec_gt) begin
               inc_b = 1'b1;
            end else begin
               emit_a = 1'b1;
               inc_a  = 1'b1;
               inc_b  = 1'b1;
            end
         end
         plbm_pkg::MODE_OR, plbm_pkg::MODE_XOR: begin
            take_b = !a_left || (b_left && (is_xor ? rec_gt : key_gt));
            take_a = !b_left || (a_left && (is_xor ? rec_lt : key_lt));
            if (!a_left && !b_left) begin
               walk_done = 1'b1;
            end else if (take_b) begin
               emit_b = !is_xor || (rd_b_data.record_no != skip_ff);
               inc_b  = 1'b1;
            end else if (take_a) begin
               emit_a = !is_xor || (rd_a_data.record_no != skip_ff);
               inc_a  = 1'b1;
            end else begin
               // Equal keys: OR emits A once, XOR marks the record as shared.
               emit_a   = !is_xor;
               set_skip = is_xor;
               inc_a    = 1'b1;
               inc_b    = 1'b1;
            end
         end
         plbm_pkg::MODE_NOT: begin
            if (!a_left) begin
               walk_done = 1'b1;
            end else if (!b_left || rec_lt) begin
               emit_a = 1'b1;
               inc_a  = 1'b1;
            end else if (rec_gt) begin
               inc_b = 1'b1;
            end else begin
               inc_a = 1'b1;
            end
         end
         default: begin
            walk_done = 1'b1;
         end
      endcase
   end

   assign step_ok = !(emit_a || emit_b) || buf_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         plbm_pkg::ST_IDLE: begin
            if (req_take && (req_data.cmd == plbm_pkg::CMD_RUN)) begin
               state_in = plbm_pkg::ST_FETCH;
            end
         end
         plbm_pkg::ST_FETCH: begin
            state_in = plbm_pkg::ST_STEP;
         end
         plbm_pkg::ST_STEP: begin
            if (walk_done) begin
               state_in = plbm_pkg::ST_FINISH;
            end else if (step_ok) begin
               state_in = plbm_pkg::ST_FETCH;
            end
         end
         plbm_pkg::ST_FINISH: begin
            if (buf_ready) begin
               state_in = plbm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = plbm_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs toward the memories and the result buffer.
   always_comb begin
      wr_a_en         = 1'b0;
      wr_b_en         = 1'b0;
      rd_en           = 1'b0;
      buf_cmd.push    = 1'b0;
      buf_cmd.finish  = 1'b0;
      buf_cmd.overflow = dropped_ff;
      buf_cmd.hit     = emit_a ? rd_a_data : rd_b_data;
      case (state_ff)
         plbm_pkg::ST_IDLE: begin
            wr_a_en = req_take && (req_data.cmd == plbm_pkg::CMD_LOAD_A) && !a_full;
            wr_b_en = req_take && (req_data.cmd == plbm_pkg::CMD_LOAD_B) && !b_full;
         end
         plbm_pkg::ST_FETCH: begin
            rd_en = 1'b1;
         end
         plbm_pkg::ST_STEP: begin
            buf_cmd.push = !walk_done && (emit_a || emit_b);
         end
         plbm_pkg::ST_FINISH: begin
            buf_cmd.finish = 1'b1;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   assign wr_a_addr = count_a_ff[AW-1:0];
   assign wr_b_addr = count_b_ff[AW-1:0];
   assign rd_a_addr = idx_a_ff[AW-1:0];
   assign rd_b_addr = idx_b_ff[AW-1:0];
   assign wr_entry.record_no    = req_data.record_no;
   assign wr_entry.field_no     = req_data.field_no;
   assign wr_entry.paragraph_no = req_data.paragraph_no;
   assign wr_entry.sentence_no  = req_data.sentence_no;
   assign wr_entry.word_pos     = req_data.word_pos;

   // Counts, walk indexes, skip record, drop flag and mode.
   always_comb begin
      mode_in    = mode_ff;
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      idx_a_in   = idx_a_ff;
      idx_b_in   = idx_b_ff;
      skip_in    = skip_ff;
      dropped_in = dropped_ff;
      if (csr_wr_en) begin
         mode_in = plbm_pkg::mode_type'(csr_wr_data);
      end
      if (wr_a_en) begin
         count_a_in = count_a_ff + CW'(1);
      end
      if (wr_b_en) begin
         count_b_in = count_b_ff + CW'(1);
      end
      if (req_take && (((req_data.cmd == plbm_pkg::CMD_LOAD_A) && a_full)
                       || ((req_data.cmd == plbm_pkg::CMD_LOAD_B) && b_full))) begin
         dropped_in = 1'b1;
      end
      if (req_take && (req_data.cmd == plbm_pkg::CMD_RUN)) begin
         idx_a_in = '0;
         idx_b_in = '0;
         skip_in  = '0;
      end
      if ((state_ff == plbm_pkg::ST_STEP) && !walk_done && step_ok) begin
         if (inc_a) begin
            idx_a_in = idx_a_ff + CW'(1);
         end
         if (inc_b) begin
            idx_b_in = idx_b_ff + CW'(1);
         end
         if (set_skip) begin
            skip_in = rd_a_data.record_no;
         end
      end
      if ((state_ff == plbm_pkg::ST_FINISH) && buf_ready) begin
         count_a_in = '0;
         count_b_in = '0;
         dropped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= plbm_pkg::ST_IDLE;
         mode_ff    <= plbm_pkg::MODE_AND;
         count_a_ff <= '0;
         count_b_ff <= '0;
         idx_a_ff   <= '0;
         idx_b_ff   <= '0;
         skip_ff    <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         mode_ff    <= mode_in;
         count_a_ff <= count_a_in;
         count_b_ff <= count_b_in;
         idx_a_ff   <= idx_a_in;
         idx_b_ff   <= idx_b_in;
         skip_ff    <= skip_in;
         dropped_ff <= dropped_in;
      end
   end

`ifndef SYNTHESIS
   // A list never holds more entries than its memory.
   assert property (@(posedge clock) disable iff (reset)
      (count_a_ff <= CW'(LIST_DEPTH)) && (count_b_ff <= CW'(LIST_DEPTH)))
      else $error("list count beyond depth");

   // The walk never runs past the loaded entries.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != plbm_pkg::ST_IDLE) |-> ((idx_a_ff <= count_a_ff) && (idx_b_ff <= count_b_ff)))
      else $error("walk index past list end");

   // Closing a run empties both lists.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == plbm_pkg::ST_FINISH) && buf_ready) |=>
      ((state_ff == plbm_pkg::ST_IDLE) && (count_a_ff == '0) && (count_b_ff == '0) && !dropped_ff))
      else $error("run did not clear the lists");
`endif

endmodule
